// ===== hw/rtl/rrqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrqs_pkg;

	// Default sizes and the reset value of the quantum register.
	localparam int NUM_CORES_DEF = 8;
	localparam int MAX_PROCS_DEF = 16;
	localparam logic [7:0] QUANTUM_RESET = 8'd5;

	// Item kinds.
	localparam logic KIND_ADMIT = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Result event codes.
	typedef enum logic [2:0] {
		EV_IDLE    = 3'd0,
		EV_EXEC    = 3'd1,
		EV_SLEEP   = 3'd2,
		EV_WOKE    = 3'd3,
		EV_FIN     = 3'd4,
		EV_PREEMPT = 3'd5,
		EV_ADMIT   = 3'd6,
		EV_REJECT  = 3'd7
	} event_t;

	// One command beat.
	typedef struct packed {
		logic        kind;
		logic [2:0]  core;
		logic [15:0] instr_total;
		logic        advance;
		logic [7:0]  sleep_len;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		event_t      event_res;
		logic [3:0]  process_slot;
		logic [15:0] prog_counter;
		logic        core_busy;
		logic [15:0] core_done_count;
	} out_item_t;

	// Ready queue control.
	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	// Slot allocator control.
	typedef struct packed {
		logic alloc;
		logic release_en;
	} alloc_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/round_robin_quantum_scheduler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Round-robin time-slice scheduler for a set of cores and process slots.
// Command channel: a beat (item) is taken at a rising edge with start high
// and busy low. busy is held low, so a beat can be issued every cycle.
// An admit beat takes the lowest free slot and queues it; a tick beat moves
// one core one step (dispatch, sleep countdown, or one instruction).
// Result channel: done is high for exactly one cycle with the result beat.
// Each command gives exactly one result: the command is held in the input
// register, then the step is worked out and registered as the result.
// Throughput is one command per cycle; all state is read for the item in
// the input register and written back at the edge that registers its result.
// The receiver cannot stall the result channel; results are never held.
// Configuration: one write channel for the quantum register; cfg_ready is
// always high. Write it only while no command is in flight.
// Reset clears the ready queue, slot occupancy, core state and finish
// counts, and sets the quantum to 5. Process tables need no clearing, as a
// slot is written on admit before any read.
module round_robin_quantum_scheduler_top #(
	parameter int NUM_CORES = rrqs_pkg::NUM_CORES_DEF,
	parameter int MAX_PROCS = rrqs_pkg::MAX_PROCS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire rrqs_pkg::in_item_t item,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [7:0]               cfg_data,
	output logic                    done,
	output rrqs_pkg::out_item_t     result
);

	localparam int SW  = $clog2(MAX_PROCS);
	localparam int CIW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

	// Input register and quantum register.
	rrqs_pkg::in_item_t item_s1;
	logic               valid_s1;
	logic [7:0]         quantum_q;

	// Process tables.
	logic [15:0] proc_pc_q    [MAX_PROCS];
	logic [15:0] proc_total_q [MAX_PROCS];
	logic [7:0]  proc_sleep_q [MAX_PROCS];

	// Core tables.
	logic [SW-1:0]        core_slot_q [NUM_CORES];
	logic [NUM_CORES-1:0] core_holds_q;
	logic [7:0]           core_run_q  [NUM_CORES];
	logic [15:0]          core_fin_q  [NUM_CORES];

	// Result register.
	rrqs_pkg::out_item_t result_q;
	logic                done_q;

	// Queue and allocator links.
	rrqs_pkg::fifo_ctl_t  fifo_ctl;
	rrqs_pkg::alloc_ctl_t alloc_ctl;
	logic [SW-1:0]        push_slot;
	logic [SW-1:0]        head_slot;
	logic                 fifo_nonempty;
	logic                 any_free;
	logic [SW-1:0]        free_slot;
	logic [SW-1:0]        release_slot;

	// Step logic signals.
	logic [CIW+2:0]      core_ext;
	logic [CIW-1:0]      cidx;
	logic                in_range;
	logic                holds;
	logic                pop;
	logic [SW-1:0]       s;
	logic [7:0]          run;
	logic [15:0]         fin_cnt;
	logic [15:0]         fin_inc;
	logic [15:0]         pc;
	logic [15:0]         tot;
	logic [7:0]          slp;
	logic [15:0]         pc_inc;
	logic [7:0]          run_inc;
	logic [SW+3:0]       slot_ext;
	logic [SW+3:0]       free_ext;
	logic                pt_we;
	logic [SW-1:0]       pt_addr;
	logic [15:0]         pt_pc;
	logic [15:0]         pt_total;
	logic [7:0]          pt_sleep;
	logic                cw_en;
	logic [SW-1:0]       cw_slot;
	logic                cw_holds;
	logic [7:0]          cw_run;
	logic [15:0]         cw_fin;
	logic                woke;
	logic                fin;
	rrqs_pkg::out_item_t res_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	rrqs_ready_fifo #(
		.MAX_PROCS(MAX_PROCS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fifo_ctl),
		.push_slot(push_slot),
		.head_slot(head_slot),
		.nonempty (fifo_nonempty)
	);

	rrqs_slot_alloc #(
		.MAX_PROCS(MAX_PROCS)
	) u_alloc (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (alloc_ctl),
		.release_slot(release_slot),
		.any_free    (any_free),
		.free_slot   (free_slot)
	);

	// Reads of the current core and process entries.
	always_comb begin
		core_ext = {CIW'(0), item_s1.core};
		cidx     = core_ext[CIW-1:0];
		in_range = core_ext < (CIW + 3)'(NUM_CORES);
		holds    = in_range && core_holds_q[cidx];
		pop      = in_range && !holds && fifo_nonempty;
		s        = pop ? head_slot : core_slot_q[cidx];
		run      = pop ? 8'd0 : core_run_q[cidx];
		fin_cnt  = core_fin_q[cidx];
		fin_inc  = (fin_cnt == 16'hFFFF) ? fin_cnt : fin_cnt + 16'd1;
		pc       = proc_pc_q[s];
		tot      = proc_total_q[s];
		slp      = proc_sleep_q[s];
		pc_inc   = (pc == 16'hFFFF) ? pc : pc + 16'd1;
		run_inc  = (run == 8'hFF) ? run : run + 8'd1;
		slot_ext = {4'd0, s};
		free_ext = {4'd0, free_slot};
	end

	// One scheduling step for the item in the input register.
	always_comb begin
		fifo_ctl     = '0;
		alloc_ctl    = '0;
		push_slot    = s;
		release_slot = s;
		pt_we        = 1'b0;
		pt_addr      = s;
		pt_pc        = pc;
		pt_total     = tot;
		pt_sleep     = slp;
		cw_en        = 1'b0;
		cw_slot      = s;
		cw_holds     = 1'b1;
		cw_run       = run;
		cw_fin       = fin_cnt;
		woke         = 1'b0;
		fin          = 1'b0;
		res_d        = '0;
		res_d.event_res = rrqs_pkg::EV_IDLE;
		if (valid_s1) begin
			if (item_s1.kind == rrqs_pkg::KIND_ADMIT) begin
				if (any_free) begin
					alloc_ctl.alloc    = 1'b1;
					fifo_ctl.push      = 1'b1;
					push_slot          = free_slot;
					pt_we              = 1'b1;
					pt_addr            = free_slot;
					pt_pc              = 16'd0;
					pt_total           = item_s1.instr_total;
					pt_sleep           = 8'd0;
					res_d.event_res    = rrqs_pkg::EV_ADMIT;
					res_d.process_slot = free_ext[3:0];
				end else begin
					res_d.event_res = rrqs_pkg::EV_REJECT;
				end
			end else if (in_range) begin
				fifo_ctl.pop = pop;
				cw_en        = 1'b1;
				if (!holds && !pop) begin
					// Idle core with an empty queue: nothing changes.
					cw_slot               = core_slot_q[cidx];
					cw_holds              = 1'b0;
					res_d.core_done_count = fin_cnt;
				end else if (slp != 8'd0) begin
					// Sleeping process: count down, give up the core.
					pt_we    = 1'b1;
					pt_sleep = slp - 8'd1;
					woke     = (pt_sleep == 8'd0);
					pt_pc    = woke ? pc_inc : pc;
					fin      = woke && (pt_pc >= tot);
					cw_holds = 1'b0;
					if (fin) begin
						alloc_ctl.release_en = 1'b1;
					end else begin
						fifo_ctl.push = 1'b1;
					end
					res_d.event_res       = woke ? rrqs_pkg::EV_WOKE : rrqs_pkg::EV_SLEEP;
					res_d.process_slot    = slot_ext[3:0];
					res_d.prog_counter    = pt_pc;
					res_d.core_done_count = fin_cnt;
				end else begin
					// Execute one instruction.
					pt_we = 1'b1;
					if (item_s1.sleep_len != 8'd0) begin
						pt_sleep = item_s1.sleep_len;
					end else if (item_s1.advance) begin
						pt_pc = pc_inc;
						fin   = (pc_inc >= tot);
					end
					cw_run             = run_inc;
					res_d.process_slot = slot_ext[3:0];
					res_d.prog_counter = pt_pc;
					if (fin) begin
						cw_fin                = fin_inc;
						cw_holds              = 1'b0;
						alloc_ctl.release_en  = 1'b1;
						res_d.event_res       = rrqs_pkg::EV_FIN;
						res_d.core_done_count = fin_inc;
					end else if (run_inc >= quantum_q) begin
						cw_holds              = 1'b0;
						fifo_ctl.push         = 1'b1;
						res_d.event_res       = rrqs_pkg::EV_PREEMPT;
						res_d.core_done_count = fin_cnt;
					end else begin
						res_d.event_res       = rrqs_pkg::EV_EXEC;
						res_d.core_busy       = 1'b1;
						res_d.core_done_count = fin_cnt;
					end
				end
			end
		end
	end

	// Control registers: input valid, result strobe, quantum, core state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
			quantum_q    <= rrqs_pkg::QUANTUM_RESET;
			core_holds_q <= '0;
			for (int i = 0; i < NUM_CORES; i++) begin
				core_slot_q[i] <= '0;
				core_run_q[i]  <= '0;
				core_fin_q[i]  <= '0;
			end
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			if (cw_en) begin
				core_slot_q[cidx]  <= cw_slot;
				core_holds_q[cidx] <= cw_holds;
				core_run_q[cidx]   <= cw_run;
				core_fin_q[cidx]   <= cw_fin;
			end
		end
	end

	// Payload registers and process tables.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result_q <= res_d;
		end
		if (pt_we) begin
			proc_pc_q[pt_addr]    <= pt_pc;
			proc_total_q[pt_addr] <= pt_total;
			proc_sleep_q[pt_addr] <= pt_sleep;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rrqs_ready_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrqs_ready_fifo #(
	parameter int MAX_PROCS = rrqs_pkg::MAX_PROCS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire rrqs_pkg::fifo_ctl_t     ctl,
	input  wire [$clog2(MAX_PROCS)-1:0]  push_slot,
	output logic [$clog2(MAX_PROCS)-1:0] head_slot,
	output logic                         nonempty
);

	localparam int SW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int TW = CW + 1;

	logic [SW-1:0] queue_q [MAX_PROCS];
	logic [SW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic [TW-1:0] tail_sum;
	logic [TW-1:0] tail_wrap;
	logic [SW-1:0] tail;
	logic [CW-1:0] count_popped;
	logic          push_ok;
	logic [SW-1:0] head_next;

	// The tail is fixed by the old head and count, pop or not.
	always_comb begin
		tail_sum  = TW'(head_q) + TW'(count_q);
		tail_wrap = (tail_sum >= TW'(MAX_PROCS)) ? tail_sum - TW'(MAX_PROCS) : tail_sum;
		tail      = tail_wrap[SW-1:0];
		count_popped = ctl.pop ? count_q - CW'(1) : count_q;
		push_ok   = ctl.push && (count_popped < CW'(MAX_PROCS));
		head_next = (head_q == SW'(MAX_PROCS - 1)) ? '0 : head_q + SW'(1);
		head_slot = queue_q[head_q];
		nonempty  = (count_q != '0);
	end

	// Head and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= head_next;
			end
			count_q <= count_popped + CW'(push_ok);
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			queue_q[tail] <= push_slot;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rrqs_slot_alloc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrqs_slot_alloc #(
	parameter int MAX_PROCS = rrqs_pkg::MAX_PROCS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire rrqs_pkg::alloc_ctl_t    ctl,
	input  wire [$clog2(MAX_PROCS)-1:0]  release_slot,
	output logic                         any_free,
	output logic [$clog2(MAX_PROCS)-1:0] free_slot
);

	localparam int SW = $clog2(MAX_PROCS);

	logic [MAX_PROCS-1:0] used_q;

	// Lowest free slot: scan downwards so the lowest index wins.
	always_comb begin
		any_free  = 1'b0;
		free_slot = '0;
		for (int i = MAX_PROCS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				any_free  = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	// Occupancy bits; allocation and release never fall in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (ctl.alloc) begin
				used_q[free_slot] <= 1'b1;
			end
			if (ctl.release_en) begin
				used_q[release_slot] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int NCORES = rrqs_pkg::NUM_CORES_DEF;
	localparam int NPROCS = rrqs_pkg::MAX_PROCS_DEF;
	localparam int unsigned STALL_LIMIT = 1000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	rrqs_pkg::in_item_t  item = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data = '0;
	logic                done;
	rrqs_pkg::out_item_t result;

	// Scheduler state as the testbench believes it to be.
	logic [7:0]  quantum_q = rrqs_pkg::QUANTUM_RESET;
	logic [3:0]  ready_q[$];
	logic [15:0] pc_tab[NPROCS];
	logic [15:0] total_tab[NPROCS];
	logic [7:0]  sleep_tab[NPROCS];
	bit          slot_taken[NPROCS];
	logic [3:0]  core_proc[NCORES];
	bit          core_active[NCORES];
	logic [7:0]  core_runs[NCORES];
	logic [15:0] core_fin[NCORES];

	rrqs_pkg::out_item_t expected_results[$];
	int unsigned failures = 0;
	int unsigned stall_cycles = 0;
	bit          no_gap_stretch = 1'b0;

	round_robin_quantum_scheduler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #5 clk = ~clk;

	// Appends a slot to the ready queue; a push onto a full queue is dropped.
	task automatic enqueue_ready(input logic [3:0] slot);
		if (ready_q.size() < NPROCS)
			ready_q.insert(ready_q.size(), slot);
	endtask

	// Works out the result of one accepted command beat and updates the state.
	task automatic predict_step(input rrqs_pkg::in_item_t cmd,
		output rrqs_pkg::out_item_t r);
		int         free_slot;
		bit         fin;
		logic [2:0] c;
		logic [3:0] s;
		r = '0;
		free_slot = -1;
		fin = 1'b0;
		c = cmd.core;
		if (cmd.kind == rrqs_pkg::KIND_ADMIT) begin
			// Lowest free slot takes the new process.
			for (int i = 0; i < NPROCS; i++)
				if (free_slot < 0 && !slot_taken[i])
					free_slot = i;
			if (free_slot < 0) begin
				r.event_res = rrqs_pkg::EV_REJECT;
			end else begin
				slot_taken[free_slot] = 1'b1;
				pc_tab[free_slot] = '0;
				total_tab[free_slot] = cmd.instr_total;
				sleep_tab[free_slot] = '0;
				enqueue_ready(free_slot[3:0]);
				r.event_res = rrqs_pkg::EV_ADMIT;
				r.process_slot = free_slot[3:0];
			end
		end else begin
			// An idle core dispatches the head of the ready queue.
			if (!core_active[c] && ready_q.size() > 0) begin
				core_proc[c] = ready_q.pop_front();
				core_active[c] = 1'b1;
				core_runs[c] = '0;
			end
			r.event_res = rrqs_pkg::EV_IDLE;
			if (core_active[c]) begin
				s = core_proc[c];
				if (sleep_tab[s] != 0) begin
					// Sleeping process counts down and always gives up the core.
					sleep_tab[s] = sleep_tab[s] - 8'd1;
					r.event_res = rrqs_pkg::EV_SLEEP;
					if (sleep_tab[s] == 0) begin
						r.event_res = rrqs_pkg::EV_WOKE;
						if (pc_tab[s] != 16'hFFFF)
							pc_tab[s] = pc_tab[s] + 16'd1;
						fin = (pc_tab[s] >= total_tab[s]);
					end
					core_active[c] = 1'b0;
					if (fin)
						slot_taken[s] = 1'b0;
					else
						enqueue_ready(s);
				end else begin
					// One instruction; a sleep request overrides the advance.
					if (cmd.sleep_len != 0) begin
						sleep_tab[s] = cmd.sleep_len;
					end else if (cmd.advance) begin
						if (pc_tab[s] != 16'hFFFF)
							pc_tab[s] = pc_tab[s] + 16'd1;
						fin = (pc_tab[s] >= total_tab[s]);
					end
					if (core_runs[c] != 8'hFF)
						core_runs[c] = core_runs[c] + 8'd1;
					if (fin) begin
						if (core_fin[c] != 16'hFFFF)
							core_fin[c] = core_fin[c] + 16'd1;
						slot_taken[s] = 1'b0;
						core_active[c] = 1'b0;
						r.event_res = rrqs_pkg::EV_FIN;
					end else if (core_runs[c] >= quantum_q) begin
						core_active[c] = 1'b0;
						enqueue_ready(s);
						r.event_res = rrqs_pkg::EV_PREEMPT;
					end else begin
						r.event_res = rrqs_pkg::EV_EXEC;
						r.core_busy = 1'b1;
					end
				end
				r.process_slot = s;
				r.prog_counter = pc_tab[s];
			end
			r.core_done_count = core_fin[c];
		end
	endtask

	// Mostly short gaps, a few long ones, none during a back-to-back stretch.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_gap_stretch || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Sends one command beat and records its expected result on acceptance.
	task automatic issue_cmd(input rrqs_pkg::in_item_t cmd);
		rrqs_pkg::out_item_t want;
		int unsigned         gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= cmd;
		do @(posedge clk); while (busy);
		predict_step(cmd, want);
		expected_results.insert(expected_results.size(), want);
	endtask

	// Lets every outstanding result arrive, then a few cycles more.
	task automatic wait_for_results();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		quantum_q = value;
	endtask

	function automatic rrqs_pkg::in_item_t admit_cmd(input logic [15:0] total);
		rrqs_pkg::in_item_t cmd;
		cmd = '0;
		cmd.kind = rrqs_pkg::KIND_ADMIT;
		cmd.instr_total = total;
		return cmd;
	endfunction

	function automatic rrqs_pkg::in_item_t tick_cmd(input logic [2:0] core,
		input logic adv, input logic [7:0] slen);
		rrqs_pkg::in_item_t cmd;
		cmd = '0;
		cmd.kind = rrqs_pkg::KIND_TICK;
		cmd.core = core;
		cmd.advance = adv;
		cmd.sleep_len = slen;
		return cmd;
	endfunction

	// Random beat; the fields that the kind ignores carry random noise.
	function automatic rrqs_pkg::in_item_t random_cmd(input int unsigned admit_pct);
		rrqs_pkg::in_item_t cmd;
		int unsigned        roll;
		cmd.core = 3'($urandom_range(0, NCORES - 1));
		cmd.instr_total = 16'($urandom);
		cmd.advance = ($urandom_range(0, 3) != 0);
		roll = $urandom_range(0, 99);
		if (roll < 84)
			cmd.sleep_len = '0;
		else if (roll < 97)
			cmd.sleep_len = 8'($urandom_range(1, 4));
		else
			cmd.sleep_len = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < admit_pct) begin
			cmd.kind = rrqs_pkg::KIND_ADMIT;
			// Short programs mostly, so that slots keep turning over.
			roll = $urandom_range(0, 99);
			if (roll < 3)
				cmd.instr_total = '0;
			else if (roll < 97)
				cmd.instr_total = 16'($urandom_range(1, 12));
			else if (roll == 99)
				cmd.instr_total = 16'($urandom);
			else
				cmd.instr_total = 16'($urandom_range(1, 40));
		end else begin
			cmd.kind = rrqs_pkg::KIND_TICK;
		end
		return cmd;
	endfunction

	task automatic run_random_traffic(input int unsigned count, input int unsigned admit_pct);
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 40 == 0)
				no_gap_stretch = ($urandom_range(0, 3) == 0);
			issue_cmd(random_cmd(admit_pct));
		end
		no_gap_stretch = 1'b0;
	endtask

	// Idle cores, admits, a zero-length program, sleep, a wake that
	// completes its program, a long sleep, quantum expiry and a normal finish.
	task automatic test_directed_sequence();
		issue_cmd(tick_cmd(3'd0, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd7, 1'b1, 8'd0));
		issue_cmd(admit_cmd(16'd0));
		issue_cmd(admit_cmd(16'd1));
		issue_cmd(admit_cmd(16'hFFFF));
		issue_cmd(admit_cmd(16'd3));
		issue_cmd(tick_cmd(3'd0, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd7, 1'b1, 8'd2));
		issue_cmd(tick_cmd(3'd7, 1'b0, 8'd0));
		issue_cmd(tick_cmd(3'd3, 1'b0, 8'd0));
		issue_cmd(tick_cmd(3'd5, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd6, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd5, 1'b1, 8'd255));
		issue_cmd(tick_cmd(3'd5, 1'b1, 8'd0));
		issue_cmd(admit_cmd(16'd2));
		repeat (4) issue_cmd(tick_cmd(3'd3, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd1, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd2, 1'b1, 8'd0));
		issue_cmd(tick_cmd(3'd2, 1'b1, 8'd0));
	endtask

	task automatic test_single_instruction_quantum();
		wait_for_results();
		write_quantum(8'd1);
		run_random_traffic(200, 25);
	endtask

	// Admit-heavy traffic so that the slot table fills and admits are refused.
	task automatic test_slot_exhaustion();
		wait_for_results();
		write_quantum(8'($urandom_range(2, 16)));
		run_random_traffic(150, 60);
	endtask

	task automatic test_long_quantum();
		wait_for_results();
		write_quantum(8'd255);
		run_random_traffic(250, 20);
	endtask

	// With a zero quantum every instruction that does not finish preempts.
	task automatic test_zero_quantum();
		wait_for_results();
		write_quantum(8'd0);
		run_random_traffic(200, 20);
	endtask

	task automatic test_mixed_quanta();
		repeat (4) begin
			wait_for_results();
			write_quantum(8'($urandom_range(2, 8)));
			run_random_traffic(60, 22);
		end
	endtask

	task automatic report_mismatch(input string field, input logic [15:0] want,
		input logic [15:0] got);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		failures++;
	endtask

	// Each result beat is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		rrqs_pkg::out_item_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: event %0d slot %0d",
					$time, result.event_res, result.process_slot);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (result.event_res !== want.event_res)
					report_mismatch("event_res", 16'(want.event_res),
						16'(result.event_res));
				if (result.process_slot !== want.process_slot)
					report_mismatch("process_slot", 16'(want.process_slot),
						16'(result.process_slot));
				if (result.prog_counter !== want.prog_counter)
					report_mismatch("prog_counter", want.prog_counter, result.prog_counter);
				if (result.core_busy !== want.core_busy)
					report_mismatch("core_busy", 16'(want.core_busy),
						16'(result.core_busy));
				if (result.core_done_count !== want.core_done_count)
					report_mismatch("core_done_count", want.core_done_count,
						result.core_done_count);
			end
		end
	end

	// Watchdog: ends the run after too long without any beat accepted.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("** round_robin_quantum_scheduler_top: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NCORES; i++) begin
			core_proc[i] = '0;
			core_active[i] = 1'b0;
			core_runs[i] = '0;
			core_fin[i] = '0;
		end
		for (int i = 0; i < NPROCS; i++)
			slot_taken[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_sequence();
		test_single_instruction_quantum();
		test_slot_exhaustion();
		test_long_quantum();
		test_zero_quantum();
		test_mixed_quanta();
		wait_for_results();

		if (failures == 0)
			$display("** round_robin_quantum_scheduler_top: PASSED **");
		else
			$display("** round_robin_quantum_scheduler_top: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rrqs_pkg.sv
hw/rtl/rrqs_ready_fifo.sv
hw/rtl/rrqs_slot_alloc.sv
hw/rtl/round_robin_quantum_scheduler_top.sv
test/tb.sv
